/* src/alive_counter_monitor_unit_defines.svh */
// Assertion macros used by the alive counter monitor top-level RTL file.
`ifndef ALIVE_COUNTER_MONITOR_UNIT_DEFINES_SVH
`define ALIVE_COUNTER_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define ACM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside of reset.
`define ACM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/acm_pkg.sv */
// Types and constants of the alive counter monitor.
package acm_pkg;

    localparam int unsigned TimerWidth = 16;
    localparam int unsigned CounterWidth = 8;
    localparam int unsigned CfgIndexWidth = 2;

    localparam logic [TimerWidth-1:0] TimerMax = '1;
    localparam logic [CounterWidth-1:0] CounterTop = 8'd15;

    // Configuration register indexes.
    localparam logic [CfgIndexWidth-1:0] CfgHoldTicks = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CfgGraceTicks = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CfgTimeoutTicks = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [TimerWidth-1:0] HoldTicksReset = 16'd100;
    localparam logic [TimerWidth-1:0] GraceTicksReset = 16'd50;
    localparam logic [TimerWidth-1:0] TimeoutTicksReset = 16'd50;

    // Item kinds.
    localparam logic ActionTick = 1'b0;
    localparam logic ActionMessage = 1'b1;

    typedef struct packed {
        logic                    action;
        logic [CounterWidth-1:0] counter_value;
    } t_in_item;

    typedef struct packed {
        logic outputs_enabled;
        logic counter_ok;
        logic awaiting_start;
        logic timed_out;
    } t_out_item;

    typedef struct packed {
        logic [TimerWidth-1:0] hold_ticks;
        logic [TimerWidth-1:0] grace_ticks;
        logic [TimerWidth-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic                    first_message_pending;
        logic                    awaiting_good_start;
        logic [CounterWidth-1:0] previous_counter;
        logic [TimerWidth-1:0]   ticks_since_good_start;
        logic [TimerWidth-1:0]   ticks_since_last_correct;
        logic [TimerWidth-1:0]   ticks_since_message;
        logic                    enable_flag;
    } t_state;

    // Saturating timer increment.
    function automatic logic [TimerWidth-1:0] sat_inc(input logic [TimerWidth-1:0] t);
        sat_inc = (t == TimerMax) ? t : t + 1'b1;
    endfunction

endpackage

/* src/acm_step.sv */
// Next-state and result logic for one tick or counter message.
module acm_step (
    input  acm_pkg::t_state   i_state,
    input  acm_pkg::t_cfg     i_cfg,
    input  acm_pkg::t_in_item i_item,
    output acm_pkg::t_state   o_state,
    output acm_pkg::t_out_item o_result
);

    logic [acm_pkg::CounterWidth:0] value_ext;
    logic [acm_pkg::CounterWidth:0] prev_ext;
    logic                           seq_ok;
    logic                           ok;
    logic                           tmo;
    logic [acm_pkg::TimerWidth-1:0] msg_inc;

    // Sequence check: previous plus one, or previous minus fifteen.
    assign value_ext = {1'b0, i_item.counter_value};
    assign prev_ext  = {1'b0, i_state.previous_counter};
    assign seq_ok    = (value_ext == prev_ext + 1'b1)
                    || (prev_ext == value_ext + {1'b0, acm_pkg::CounterTop});
    assign ok = (i_item.action == acm_pkg::ActionMessage)
             && !i_state.first_message_pending
             && (i_item.counter_value <= acm_pkg::CounterTop)
             && seq_ok;

    assign msg_inc = acm_pkg::sat_inc(i_state.ticks_since_message);
    assign tmo = (i_item.action == acm_pkg::ActionTick) && (msg_inc > i_cfg.timeout_ticks);

    // State update for the item.
    always_comb begin
        o_state = i_state;
        if (i_item.action == acm_pkg::ActionTick) begin
            o_state.ticks_since_good_start   = acm_pkg::sat_inc(i_state.ticks_since_good_start);
            o_state.ticks_since_last_correct =
                acm_pkg::sat_inc(i_state.ticks_since_last_correct);
            o_state.ticks_since_message      = msg_inc;
            if (tmo) begin
                o_state.enable_flag         = 1'b0;
                o_state.awaiting_good_start = 1'b1;
            end
        end else begin
            if (ok) begin
                if (i_state.awaiting_good_start) begin
                    o_state.awaiting_good_start    = 1'b0;
                    o_state.ticks_since_good_start = '0;
                    o_state.enable_flag            = 1'b0;
                end else if (i_state.ticks_since_good_start > i_cfg.hold_ticks) begin
                    o_state.enable_flag              = 1'b1;
                    o_state.ticks_since_last_correct = '0;
                end
            end else if (i_state.ticks_since_last_correct < i_cfg.grace_ticks) begin
                o_state.enable_flag = 1'b1;
            end else begin
                o_state.enable_flag         = 1'b0;
                o_state.awaiting_good_start = 1'b1;
            end
            o_state.first_message_pending = 1'b0;
            o_state.previous_counter      = i_item.counter_value;
            o_state.ticks_since_message   = '0;
        end
    end

    // Enable and start fields reflect the state after the item; counter_ok and timed_out come from its checks.
    always_comb begin
        o_result.outputs_enabled = o_state.enable_flag;
        o_result.counter_ok      = ok;
        o_result.awaiting_start  = o_state.awaiting_good_start;
        o_result.timed_out       = tmo;
    end

endmodule

/* src/alive_counter_monitor_unit.sv */
// Top level of the alive counter monitor: input register, update logic, result register.
//
//  Channel  Direction  Handshake               Beat
//  in       input      i_in_valid / o_in_stall  t_in_item (action, counter_value)
//  out      output     o_out_valid / i_out_stall t_out_item (four status bits)
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One beat is taken per clock while o_in_stall is low; it passes through the input register, then the result register.
// The monitor state sits beside the result register and updates in the same edge,
// so the next item always sees the state left by the previous one.
// Reset restores the default register values and the start-up monitor state.
// A stall on the output holds the result and, once the input register is full,
// raises o_in_stall in the same cycle.
module alive_counter_monitor_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  acm_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output acm_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [acm_pkg::CfgIndexWidth-1:0]   i_cfg_index,
    input  logic [acm_pkg::TimerWidth-1:0]      i_cfg_data
);

    `include "alive_counter_monitor_unit_defines.svh"

    logic               r_in_valid;
    acm_pkg::t_in_item  r_in_data;
    logic               r_out_valid;
    acm_pkg::t_out_item r_out_data;
    acm_pkg::t_state    r_state;
    acm_pkg::t_cfg      r_cfg;

    acm_pkg::t_state    n_state;
    acm_pkg::t_out_item n_result;

    logic advance;
    logic in_accept;

    // Handshake: the input register moves on whenever the result register can take it.
    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    acm_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in_data),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_accept) begin
            r_in_data <= i_in_data;
        end
    end

    // Result register and monitor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid                      <= 1'b0;
            r_state.first_message_pending    <= 1'b1;
            r_state.awaiting_good_start      <= 1'b1;
            r_state.previous_counter         <= '0;
            r_state.ticks_since_good_start   <= '0;
            r_state.ticks_since_last_correct <= acm_pkg::TimerMax;
            r_state.ticks_since_message      <= acm_pkg::TimerMax;
            r_state.enable_flag              <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
        if (advance && r_in_valid) begin
            r_out_data <= n_result;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ticks    <= acm_pkg::HoldTicksReset;
            r_cfg.grace_ticks   <= acm_pkg::GraceTicksReset;
            r_cfg.timeout_ticks <= acm_pkg::TimeoutTicksReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                acm_pkg::CfgHoldTicks:    r_cfg.hold_ticks    <= i_cfg_data;
                acm_pkg::CfgGraceTicks:   r_cfg.grace_ticks   <= i_cfg_data;
                acm_pkg::CfgTimeoutTicks: r_cfg.timeout_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A timeout always leaves the enable cleared and the start state armed.
    `ACM_ASSERT_IMP(a_timeout_disables, i_clk, i_rst_n,
        o_out_valid && o_out_data.timed_out,
        !o_out_data.outputs_enabled && o_out_data.awaiting_start,
        "timeout result with enable set or start not armed")

    // A tick never reports a good counter, a message never reports a timeout.
    `ACM_ASSERT_IMP(a_ok_xor_timeout, i_clk, i_rst_n,
        o_out_valid,
        !(o_out_data.counter_ok && o_out_data.timed_out),
        "counter_ok and timed_out both set")

    // A processed message restarts the message timer.
    `ACM_ASSERT_NEXT(a_msg_clears_timer, i_clk, i_rst_n,
        advance && r_in_valid && (r_in_data.action == acm_pkg::ActionMessage),
        r_state.ticks_since_message == '0 && !r_state.first_message_pending,
        "message did not restart the message timer")

    // Only a message can leave the first-message state.
    `ACM_ASSERT_IMP(a_first_cleared_by_msg, i_clk, i_rst_n,
        $fell(r_state.first_message_pending),
        $past(advance && r_in_valid && (r_in_data.action == acm_pkg::ActionMessage)),
        "first-message flag cleared without a message")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the alive counter monitor: driver, monitor and status predictor.
module tb_top;
    import acm_pkg::*;

    // Receiver stall patterns.
    typedef enum int {
        StallNone,
        StallLight,
        StallHeavy,
        StallPeriodic
    } t_stall_mode;

    localparam int unsigned SettleCycles = 8;
    localparam int unsigned DrainCycles = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CfgIndexWidth-1:0] i_cfg_index = CfgHoldTicks;
    logic [TimerWidth-1:0] i_cfg_data = '0;

    // Beats waiting to be sent and status words waiting to be seen.
    t_in_item beat_queue[$];
    t_out_item status_expect[$];
    int mismatch_count = 0;

    // Shadow of the monitor registers and state.
    t_cfg shadow_cfg;
    logic sh_first_pending;
    logic sh_awaiting;
    logic [CounterWidth-1:0] sh_prev;
    logic [TimerWidth-1:0] sh_good_age;
    logic [TimerWidth-1:0] sh_correct_age;
    logic [TimerWidth-1:0] sh_msg_age;
    logic sh_enabled;

    // Sender burst and receiver stall bookkeeping.
    int burst_left = 0;
    int gap_left = 0;
    t_stall_mode stall_mode = StallNone;
    int stall_left = 0;
    int stall_phase = 0;

    alive_counter_monitor_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a 20 unit period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Saturating age counter step.
    function automatic logic [TimerWidth-1:0] age_step(input logic [TimerWidth-1:0] age);
        return (age == TimerMax) ? age : age + 1'b1;
    endfunction

    // Start-up state of the monitor and its default register values.
    task automatic reset_shadow();
        shadow_cfg.hold_ticks = HoldTicksReset;
        shadow_cfg.grace_ticks = GraceTicksReset;
        shadow_cfg.timeout_ticks = TimeoutTicksReset;
        sh_first_pending = 1'b1;
        sh_awaiting = 1'b1;
        sh_prev = '0;
        sh_good_age = '0;
        sh_correct_age = TimerMax;
        sh_msg_age = TimerMax;
        sh_enabled = 1'b0;
    endtask

    // Advances the shadow state by one beat and returns the status it should produce.
    function automatic t_out_item predict_status(input t_in_item beat);
        t_out_item status;
        int diff;
        logic good;
        good = 1'b0;
        status.timed_out = 1'b0;
        if (beat.action == ActionTick) begin
            sh_good_age = age_step(sh_good_age);
            sh_correct_age = age_step(sh_correct_age);
            sh_msg_age = age_step(sh_msg_age);
            if (sh_msg_age > shadow_cfg.timeout_ticks) begin
                status.timed_out = 1'b1;
                sh_enabled = 1'b0;
                sh_awaiting = 1'b1;
            end
        end else begin
            diff = int'(beat.counter_value) - int'(sh_prev);
            good = !sh_first_pending && beat.counter_value <= CounterTop
                   && (diff == 1 || diff == -int'(CounterTop));
            if (good) begin
                if (sh_awaiting) begin
                    sh_awaiting = 1'b0;
                    sh_good_age = '0;
                    sh_enabled = 1'b0;
                end else if (sh_good_age > shadow_cfg.hold_ticks) begin
                    sh_enabled = 1'b1;
                    sh_correct_age = '0;
                end
            end else if (sh_correct_age < shadow_cfg.grace_ticks) begin
                sh_enabled = 1'b1;
            end else begin
                sh_enabled = 1'b0;
                sh_awaiting = 1'b1;
            end
            sh_first_pending = 1'b0;
            sh_prev = beat.counter_value;
            sh_msg_age = '0;
        end
        status.outputs_enabled = sh_enabled;
        status.counter_ok = good;
        status.awaiting_start = sh_awaiting;
        return status;
    endfunction

    // Reports one status bit that differs from the prediction.
    task automatic compare_bit(input string field, input logic want, input logic got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %b, actual %b", $time, field, want, got);
        end
    endtask

    // Queues a tick; its counter field carries noise that must be ignored.
    task automatic push_tick();
        t_in_item beat;
        beat.action = ActionTick;
        beat.counter_value = CounterWidth'($urandom_range(0, 255));
        beat_queue.push_back(beat);
    endtask

    task automatic push_msg(input int value);
        t_in_item beat;
        beat.action = ActionMessage;
        beat.counter_value = CounterWidth'(value);
        beat_queue.push_back(beat);
    endtask

    // Waits until every queued beat is sent and every status word has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        while (beat_queue.size() != 0 || i_in_valid || status_expect.size() != 0)
            @(negedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // One register write over the configuration channel.
    task automatic write_reg(input logic [CfgIndexWidth-1:0] index,
                             input logic [TimerWidth-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CfgHoldTicks:    shadow_cfg.hold_ticks = value;
            CfgGraceTicks:   shadow_cfg.grace_ticks = value;
            CfgTimeoutTicks: shadow_cfg.timeout_ticks = value;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int hold, input int grace, input int timeout);
        wait_idle();
        write_reg(CfgHoldTicks, TimerWidth'(hold));
        write_reg(CfgGraceTicks, TimerWidth'(grace));
        write_reg(CfgTimeoutTicks, TimerWidth'(timeout));
    endtask

    // Mostly a well-behaved partner counting up with ticks between messages,
    // mixed with repeats, skips and arbitrary values.
    task automatic add_traffic(input int count, input int max_ticks);
        int sent;
        int run;
        int roll;
        int seq;
        sent = 0;
        seq = $urandom_range(0, 15);
        while (sent < count) begin
            run = $urandom_range(0, max_ticks);
            while (run > 0 && sent < count) begin
                push_tick();
                sent++;
                run--;
            end
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                seq = (seq + 1) % 16;
                push_msg(seq);
            end else if (roll < 88) begin
                push_msg($urandom_range(0, 255));
            end else if (roll < 94) begin
                push_msg(seq);
            end else begin
                seq = (seq + 2) % 16;
                push_msg(seq);
            end
            sent++;
        end
    endtask

    // Sender: bursts of beats separated by random gaps; a stalled beat is held.
    always @(posedge i_clk) begin : drive_beats
        t_in_item next_beat;
        logic next_valid;
        next_beat = i_in_data;
        next_valid = 1'b0;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                status_expect.push_back(predict_status(i_in_data));
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (beat_queue.size() != 0) begin
                    next_beat = beat_queue.pop_front();
                    next_valid = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 5))
                            0, 1, 2: gap_left = 0;
                            3, 4:    gap_left = $urandom_range(1, 4);
                            default: gap_left = $urandom_range(5, 30);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end
                i_in_valid <= next_valid;
                i_in_data <= next_beat;
            end
        end
    end

    // Receiver: checks each accepted status word and stalls on a changing pattern.
    always @(posedge i_clk) begin : watch_status
        t_out_item want;
        logic next_stall;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (status_expect.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected status, expected none, actual %b",
                             $time, o_out_data);
                end else begin
                    want = status_expect.pop_front();
                    compare_bit("outputs_enabled", want.outputs_enabled,
                                o_out_data.outputs_enabled);
                    compare_bit("counter_ok", want.counter_ok, o_out_data.counter_ok);
                    compare_bit("awaiting_start", want.awaiting_start,
                                o_out_data.awaiting_start);
                    compare_bit("timed_out", want.timed_out, o_out_data.timed_out);
                end
            end
            if (stall_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_left = $urandom_range(8, 80);
            end else begin
                stall_left--;
            end
            stall_phase = (stall_phase + 1) % 3;
            case (stall_mode)
                StallLight:    next_stall = ($urandom_range(0, 99) < 30);
                StallHeavy:    next_stall = ($urandom_range(0, 99) < 70);
                StallPeriodic: next_stall = (stall_phase == 0);
                default:       next_stall = 1'b0;
            endcase
            i_out_stall <= next_stall;
        end
    end

    // Run limit.
    initial begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus sequence.
    initial begin : stimulus
        int waited;
        reset_shadow();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: timeout from the saturated start, first message,
        // start-up, hold not yet met, out-of-range value.
        push_tick();
        push_msg(0);
        push_msg(1);
        push_msg(2);
        push_msg(255);

        // Short windows: release after hold, grace, fault, wrap and timeout.
        set_config(2, 3, 4);
        push_msg(0);
        push_msg(1);
        repeat (3) push_tick();
        push_msg(2);
        push_msg(3);
        push_msg(9);
        repeat (3) push_tick();
        push_msg(5);
        // A stored out-of-range value can still be followed by a value 15 below it.
        push_msg(16);
        push_msg(1);
        push_msg(15);
        push_msg(0);
        repeat (5) push_tick();

        set_config(3, 4, 5);
        add_traffic(150, 7);
        set_config(0, 0, 0);
        add_traffic(80, 2);
        set_config(65535, 65535, 65535);
        add_traffic(80, 6);
        set_config($urandom_range(0, 10), $urandom_range(0, 10), $urandom_range(0, 10));
        add_traffic(150, 12);
        set_config($urandom_range(0, 65535), $urandom_range(0, 8), $urandom_range(0, 65535));
        add_traffic(80, 10);
        set_config($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6));
        add_traffic(100, 9);

        // Hold windows at the top of the range are never exceeded by a short run.
        set_config(65535, 0, 65535);
        push_msg(5);
        push_msg(6);
        repeat (20) push_tick();
        push_msg(7);
        set_config(65534, 0, 65535);
        push_msg(8);
        push_tick();

        // Drain and settle.
        @(negedge i_clk);
        while (beat_queue.size() != 0 || i_in_valid) @(negedge i_clk);
        waited = 0;
        while (status_expect.size() != 0 && waited < DrainCycles) begin
            @(negedge i_clk);
            waited++;
        end
        if (status_expect.size() != 0) begin
            mismatch_count++;
            $display("%0t: missing status, expected %0d more, actual none",
                     $time, status_expect.size());
        end
        repeat (SettleCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/acm_pkg.sv
src/acm_step.sv
src/alive_counter_monitor_unit.sv
tb/tb_top.sv
